// ===== sv/nlc_pkg.sv =====
// shared types and constants for the normalized linear classifier
package nlc_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STATS = 2'd1;
  localparam logic [1:0] OP_CLASS = 2'd2;
  localparam logic [1:0] OP_LABEL = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         class_index;
    logic [4:0]         column_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  predicted_class;
    logic        mispredicted;
    logic [31:0] rows_seen;
    logic [31:0] wrong_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STAT_RD,
    ST_STAT_WR,
    ST_CLS_RD,
    ST_DIV,
    ST_W_RD,
    ST_W_WAIT,
    ST_MUL,
    ST_ACC,
    ST_BIAS_RD,
    ST_BIAS_WAIT,
    ST_BIAS_ACC,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

// ===== sv/nlc_ram.sv =====
// generic single port ram with registered read
module nlc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 84
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/normalized_linear_classifier_top.sv =====
// top level of the normalized linear classifier
//
// Usage: drive in_item and pulse start while busy is low; the beat is taken
// at that edge and busy rises until the item is done. Operations: load a
// weight or bias, update a column's running min and max, classify one feature
// into all class scores, or close a row with its label.
// Only a label beat gives a result: out_valid is high for one cycle with
// out_item, and the receiver cannot stall it.
// Steps of each operation:
//   load              a weight ram write
//   statistics        read min/max memories, then write back
//   classify          a ram read, a setup step and 49 steps
//                     of the bit-serial restoring divider for (v-min)*2^16/range,
//                     then per class a read, wait, multiply and add on one
//                     shared 32x32 multiplier; no divider when the range is not
//                     positive or v-min is zero, only setup for an ignored column
//   label             bias adds then a serial compare; result beat as busy falls
// Class scores live in flip-flops; weights, minima and maxima live in rams.
// Reset clears scores, counters and the min/max valid bits; an unwritten
// column reads as most positive min and most negative max.
module normalized_linear_classifier_top #(
  parameter int NUM_FEATURES = 20,
  parameter int NUM_CLASSES  = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  nlc_pkg::in_item_t  in_item,
  output logic               out_valid,
  output nlc_pkg::out_item_t out_item
);

  localparam int ROW_LEN = NUM_FEATURES + 1;
  localparam int DEPTH   = NUM_CLASSES * ROW_LEN;
  localparam int AW      = $clog2(DEPTH);
  localparam int FW      = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int CW      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int KW      = $clog2(NUM_CLASSES + 1);
  localparam int DIVN    = 49;  // quotient bits: numerator < 2^49

  nlc_pkg::state_t state_r, state_nxt;
  nlc_pkg::in_item_t item_r, item_nxt;

  logic [KW-1:0] k_r, k_nxt;
  logic [5:0]    dcnt_r, dcnt_nxt;
  logic [48:0]   quo_r, quo_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [48:0]   num_r, num_nxt;
  logic [32:0]   den_r, den_nxt;
  logic          neg_r, neg_nxt;
  logic signed [31:0] norm_r, norm_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [31:0] mn_r, mn_nxt, mx_r, mx_nxt;
  logic [CW-1:0] win_r, win_nxt;
  logic [31:0]   rows_r, rows_nxt, errs_r, errs_nxt;
  logic [63:0]   score_r [NUM_CLASSES];
  logic [63:0]   score_nxt [NUM_CLASSES];
  logic [NUM_FEATURES-1:0] cvalid_r, cvalid_nxt;
  logic          out_valid_r, out_valid_nxt;
  nlc_pkg::out_item_t out_r, out_nxt;

  // weight ram
  logic            w_we;
  logic [AW-1:0]   w_addr;
  logic [31:0]     w_rdata;
  // min and max rams
  logic            m_we;
  logic [FW-1:0]   m_addr;
  logic [31:0]     mn_rdata, mx_rdata;

  nlc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_wram (
    .clk(clk), .we(w_we), .addr(w_addr), .wdata(item_r.value), .rdata(w_rdata)
  );
  nlc_ram #(.WIDTH(32), .DEPTH(NUM_FEATURES)) u_minram (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(mn_r), .rdata(mn_rdata)
  );
  nlc_ram #(.WIDTH(32), .DEPTH(NUM_FEATURES)) u_maxram (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(mx_r), .rdata(mx_rdata)
  );

  logic [4:0] col;
  logic       col_ok;
  logic       cvalid;
  logic signed [31:0] cur_mn, cur_mx;
  logic signed [32:0] range_s, diff_s;
  logic [32:0]        diff_abs;
  logic [33:0]        rem_sh;
  logic [33:0]        rem_sub;
  logic signed [63:0] score_k, score_w;
  logic [63:0]        add_b;
  logic [63:0]        add_sum;

  assign col    = item_r.column_index;
  assign col_ok = ({27'd0, col} < NUM_FEATURES);
  assign m_addr = col[FW-1:0];
  assign cvalid = col_ok ? cvalid_r[m_addr] : 1'b0;
  assign cur_mn = cvalid ? mn_rdata : 32'sh7FFFFFFF;
  assign cur_mx = cvalid ? mx_rdata : 32'sh80000000;
  assign range_s = {cur_mx[31], cur_mx} - {cur_mn[31], cur_mn};
  assign diff_s  = {item_r.value[31], item_r.value} - {cur_mn[31], cur_mn};
  assign diff_abs = diff_s[32] ? 33'(-diff_s) : 33'(diff_s);
  assign rem_sh  = {rem_r, num_r[48]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  // single shared adder for score updates
  always_comb begin
    score_k = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (k_r == KW'(i)) score_k = score_r[i];
    end
    score_w = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (win_r == CW'(i)) score_w = score_r[i];
    end
  end
  assign add_sum = score_k + add_b;

  // weight address: class k (or loaded class) times row length plus column
  // the address is held through the wait state so the read data stays valid
  always_comb begin
    if (state_r == nlc_pkg::ST_IDLE || state_r == nlc_pkg::ST_DONE) begin
      w_addr = AW'(in_item.class_index * ROW_LEN + in_item.column_index);
    end else if (state_r == nlc_pkg::ST_BIAS_RD || state_r == nlc_pkg::ST_BIAS_WAIT) begin
      w_addr = AW'(k_r * ROW_LEN + NUM_FEATURES);
    end else if (state_r == nlc_pkg::ST_W_RD || state_r == nlc_pkg::ST_W_WAIT) begin
      w_addr = AW'(k_r * ROW_LEN + col);
    end else begin
      w_addr = AW'(item_r.class_index * ROW_LEN + col);
    end
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    k_nxt = k_r;
    dcnt_nxt = dcnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    num_nxt = num_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    norm_nxt = norm_r;
    prod_nxt = prod_r;
    mn_nxt = mn_r;
    mx_nxt = mx_r;
    win_nxt = win_r;
    rows_nxt = rows_r;
    errs_nxt = errs_r;
    cvalid_nxt = cvalid_r;
    out_valid_nxt = 1'b0;
    out_nxt = out_r;
    w_we = 1'b0;
    m_we = 1'b0;
    add_b = '0;
    for (int i = 0; i < NUM_CLASSES; i++) score_nxt[i] = score_r[i];

    case (state_r)
      nlc_pkg::ST_IDLE, nlc_pkg::ST_DONE: begin
        state_nxt = nlc_pkg::ST_IDLE;
        if (start) begin
          item_nxt = in_item;
          k_nxt = '0;
          case (in_item.operation)
            nlc_pkg::OP_LOAD:  state_nxt = nlc_pkg::ST_DONE;
            nlc_pkg::OP_STATS: state_nxt = nlc_pkg::ST_STAT_RD;
            nlc_pkg::OP_CLASS: state_nxt = nlc_pkg::ST_CLS_RD;
            default:           state_nxt = nlc_pkg::ST_BIAS_RD;
          endcase
          if (in_item.operation == nlc_pkg::OP_LOAD) begin
            state_nxt = nlc_pkg::ST_STAT_WR;
          end
        end
      end
      nlc_pkg::ST_STAT_WR: begin
        // load write (weights) or min/max write-back (statistics)
        if (item_r.operation == nlc_pkg::OP_LOAD) begin
          w_we = ({30'd0, item_r.class_index} < NUM_CLASSES) &&
                 ({27'd0, col} <= NUM_FEATURES);
        end else if (col_ok) begin
          m_we = 1'b1;
          cvalid_nxt[m_addr] = 1'b1;
        end
        state_nxt = nlc_pkg::ST_IDLE;
      end
      nlc_pkg::ST_STAT_RD: begin
        state_nxt = nlc_pkg::ST_MUL;
      end
      nlc_pkg::ST_CLS_RD: begin
        state_nxt = nlc_pkg::ST_DIV;
      end
      nlc_pkg::ST_MUL: begin
        if (item_r.operation == nlc_pkg::OP_STATS) begin
          // ram data valid now: pick new extremes
          mn_nxt = (item_r.value < cur_mn) ? item_r.value : cur_mn;
          mx_nxt = (item_r.value > cur_mx) ? item_r.value : cur_mx;
          state_nxt = nlc_pkg::ST_STAT_WR;
        end else begin
          prod_nxt = $signed(w_rdata) * norm_r;
          state_nxt = nlc_pkg::ST_ACC;
        end
      end
      nlc_pkg::ST_DIV: begin
        if (dcnt_r == 6'd0 && quo_r == '0 && rem_r == '0 && num_r == '0) begin
          // setup step
          if (!col_ok) begin
            state_nxt = nlc_pkg::ST_IDLE;
          end else if (range_s <= 0 || diff_abs == '0) begin
            norm_nxt = '0;
            state_nxt = nlc_pkg::ST_W_RD;
          end else begin
            num_nxt = {diff_abs[32:0], 16'd0};
            den_nxt = range_s;
            neg_nxt = diff_s[32];
            dcnt_nxt = 6'(DIVN);
          end
        end else begin
          if (rem_sub[33]) begin
            rem_nxt = rem_sh[32:0];
            quo_nxt = {quo_r[47:0], 1'b0};
          end else begin
            rem_nxt = rem_sub[32:0];
            quo_nxt = {quo_r[47:0], 1'b1};
          end
          num_nxt = {num_r[47:0], 1'b0};
          dcnt_nxt = dcnt_r - 6'd1;
          if (dcnt_r == 6'd1) begin
            // saturate magnitude to q15.16 with sign
            if (!neg_r) begin
              norm_nxt = (quo_nxt > 49'h0_7FFF_FFFF) ? 32'sh7FFFFFFF : quo_nxt[31:0];
            end else begin
              norm_nxt = (quo_nxt > 49'h0_8000_0000) ? 32'sh80000000
                                                      : 32'(-quo_nxt[31:0]);
            end
            quo_nxt = '0;
            rem_nxt = '0;
            num_nxt = '0;
            dcnt_nxt = '0;
            state_nxt = nlc_pkg::ST_W_RD;
          end
        end
      end
      nlc_pkg::ST_W_RD: begin
        state_nxt = nlc_pkg::ST_W_WAIT;
      end
      nlc_pkg::ST_W_WAIT: begin
        state_nxt = nlc_pkg::ST_MUL;
      end
      nlc_pkg::ST_ACC: begin
        add_b = 64'(prod_r >>> 16);
        score_nxt[k_r[CW-1:0]] = add_sum;
        if (k_r == KW'(NUM_CLASSES - 1)) begin
          state_nxt = nlc_pkg::ST_IDLE;
        end else begin
          k_nxt = k_r + KW'(1);
          state_nxt = nlc_pkg::ST_W_RD;
        end
      end
      nlc_pkg::ST_BIAS_RD: begin
        state_nxt = nlc_pkg::ST_BIAS_WAIT;
      end
      nlc_pkg::ST_BIAS_WAIT: begin
        state_nxt = nlc_pkg::ST_BIAS_ACC;
      end
      nlc_pkg::ST_BIAS_ACC: begin
        add_b = {{32{w_rdata[31]}}, w_rdata};
        score_nxt[k_r[CW-1:0]] = add_sum;
        if (k_r == KW'(NUM_CLASSES - 1)) begin
          k_nxt = KW'(1);
          win_nxt = '0;
          state_nxt = nlc_pkg::ST_CMP;
        end else begin
          k_nxt = k_r + KW'(1);
          state_nxt = nlc_pkg::ST_BIAS_RD;
        end
      end
      nlc_pkg::ST_CMP: begin
        // one signed compare per cycle, first wins on ties
        if (k_r == KW'(NUM_CLASSES)) begin
          out_nxt.predicted_class = 2'(win_r);
          out_nxt.mispredicted = ({{(32-CW){1'b0}}, win_r} !=
                                  {30'd0, item_r.class_index});
          rows_nxt = (rows_r != '1) ? rows_r + 32'd1 : rows_r;
          errs_nxt = (out_nxt.mispredicted && errs_r != '1) ? errs_r + 32'd1 : errs_r;
          out_nxt.rows_seen = rows_nxt;
          out_nxt.wrong_count = errs_nxt;
          out_valid_nxt = 1'b1;
          for (int i = 0; i < NUM_CLASSES; i++) score_nxt[i] = '0;
          state_nxt = nlc_pkg::ST_IDLE;
        end else begin
          if ($signed(score_k) > score_w) win_nxt = k_r[CW-1:0];
          k_nxt = k_r + KW'(1);
        end
      end
      default: state_nxt = nlc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nlc_pkg::ST_IDLE;
      rows_r <= '0;
      errs_r <= '0;
      cvalid_r <= '0;
      out_valid_r <= 1'b0;
      dcnt_r <= '0;
      quo_r <= '0;
      rem_r <= '0;
      num_r <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) score_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      rows_r <= rows_nxt;
      errs_r <= errs_nxt;
      cvalid_r <= cvalid_nxt;
      out_valid_r <= out_valid_nxt;
      dcnt_r <= dcnt_nxt;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      for (int i = 0; i < NUM_CLASSES; i++) score_r[i] <= score_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    k_r <= k_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    norm_r <= norm_nxt;
    prod_r <= prod_nxt;
    mn_r <= mn_nxt;
    mx_r <= mx_nxt;
    win_r <= win_nxt;
    out_r <= out_nxt;
  end

  assign busy = (state_r != nlc_pkg::ST_IDLE) && (state_r != nlc_pkg::ST_DONE);
  assign out_valid = out_valid_r;
  assign out_item = out_r;

endmodule

// ===== tb/sv/normalized_linear_classifier_top_tb.sv =====
// self-checking testbench for the normalized linear classifier top level
`timescale 1ns / 1ps

module normalized_linear_classifier_top_tb;

  localparam int NF = 20;
  localparam int NC = 4;
  localparam int ROWW = NF + 1;
  localparam int WATCHDOG = 20000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  nlc_pkg::in_item_t in_item;
  logic out_valid;
  nlc_pkg::out_item_t out_item;

  normalized_linear_classifier_top #(.NUM_FEATURES(NF), .NUM_CLASSES(NC)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  logic signed [31:0] weights [NC*ROWW];
  logic signed [31:0] col_min [NF];
  logic signed [31:0] col_max [NF];
  logic signed [63:0] scores [NC];
  logic [31:0] row_cnt;
  logic [31:0] err_cnt;

  nlc_pkg::out_item_t label_queue [$];
  int mismatches;
  int items_sent;
  int labels_seen;
  int idle_cycles;
  int send_idle_pct;

  function automatic logic signed [31:0] scale_feature(logic signed [31:0] v, int c);
    logic signed [63:0] span;
    logic signed [63:0] q;
    span = 64'(col_max[c]) - 64'(col_min[c]);
    if (span <= 0) return 32'sd0;
    q = ((64'(v) - 64'(col_min[c])) * 64'sd65536) / span;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  task automatic predict_beat(nlc_pkg::in_item_t it);
    int c;
    int k;
    int win;
    logic signed [31:0] nf;
    logic signed [63:0] prod;
    nlc_pkg::out_item_t r;
    c = int'(it.column_index);
    case (it.operation)
      nlc_pkg::OP_LOAD: begin
        if (c <= NF) weights[it.class_index*ROWW + c] = it.value;
      end
      nlc_pkg::OP_STATS: begin
        if (c < NF) begin
          if (it.value > col_max[c]) col_max[c] = it.value;
          if (it.value < col_min[c]) col_min[c] = it.value;
        end
      end
      nlc_pkg::OP_CLASS: begin
        if (c < NF) begin
          nf = scale_feature(it.value, c);
          for (k = 0; k < NC; k++) begin
            prod = 64'(weights[k*ROWW + c]) * 64'(nf);
            scores[k] = scores[k] + (prod >>> 16);
          end
        end
      end
      default: begin
        for (k = 0; k < NC; k++) scores[k] = scores[k] + 64'(weights[k*ROWW + NF]);
        win = 0;
        for (k = 1; k < NC; k++) if (scores[k] > scores[win]) win = k;
        r.predicted_class = win[1:0];
        r.mispredicted = (win[1:0] != it.class_index);
        if (row_cnt != 32'hFFFFFFFF) row_cnt = row_cnt + 32'd1;
        if (r.mispredicted && err_cnt != 32'hFFFFFFFF) err_cnt = err_cnt + 32'd1;
        r.rows_seen = row_cnt;
        r.wrong_count = err_cnt;
        for (k = 0; k < NC; k++) scores[k] = '0;
        label_queue.push_back(r);
      end
    endcase
  endtask

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      labels_seen <= labels_seen + 1;
      if (label_queue.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result beat %p", out_item);
      end else begin
        if (out_item !== label_queue[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result mismatch: exp %p got %p", label_queue[0], out_item);
        end
        void'(label_queue.pop_front());
      end
    end
  end

  // watchdog on cycles with no accepted beat or result beat
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog expired");
      $display("normalized_linear_classifier_top regression: fail");
      $finish;
    end
  end

  // the beat is accepted at the edge where busy is seen low
  task automatic send_beat(nlc_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_beat(it);
    items_sent++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic nlc_pkg::in_item_t make_beat(logic [1:0] op, logic [1:0] cls,
                                                  logic [4:0] col, logic [31:0] v);
    nlc_pkg::in_item_t it;
    it.operation = op;
    it.class_index = cls;
    it.column_index = col;
    it.value = v;
    return it;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($urandom_range(131072)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    while (label_queue.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // directed table; label rows with a typed result are after reset, weights zero
  typedef struct {
    nlc_pkg::in_item_t beat;
    bit has_exp;
    nlc_pkg::out_item_t exp_res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  task automatic add_row(logic [1:0] op, logic [1:0] cls, logic [4:0] col,
                         logic [31:0] v, bit he, nlc_pkg::out_item_t e);
    dir_row_t r;
    r.beat = make_beat(op, cls, col, v);
    r.has_exp = he;
    r.exp_res = e;
    dir_rows.push_back(r);
  endtask

  initial begin
    int i;
    int k;
    int phase;
    int col;
    nlc_pkg::out_item_t none;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    mismatches = 0;
    items_sent = 0;
    labels_seen = 0;
    idle_cycles = 0;
    send_idle_pct = 9;
    none = '0;
    for (i = 0; i < NC*ROWW; i++) weights[i] = '0;
    for (i = 0; i < NF; i++) begin
      col_min[i] = 32'sh7FFFFFFF;
      col_max[i] = 32'sh80000000;
    end
    for (i = 0; i < NC; i++) scores[i] = '0;
    row_cnt = '0;
    err_cnt = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all weights written first so no unwritten entry is ever read
    for (k = 0; k < NC; k++)
      for (i = 0; i < ROWW; i++)
        add_row(nlc_pkg::OP_LOAD, 2'(k), 5'(i), 32'h0, 1'b0, none);
    // empty-range classify and ties: class 0 wins, labels 0 and 3
    add_row(nlc_pkg::OP_CLASS, 2'd1, 5'd0, 32'h7FFFFFFF, 1'b0, none);
    add_row(nlc_pkg::OP_LABEL, 2'd0, 5'd0, 32'h0, 1'b1, '{2'd0, 1'b0, 32'd1, 32'd0});
    add_row(nlc_pkg::OP_LABEL, 2'd3, 5'd31, 32'h0, 1'b1, '{2'd0, 1'b1, 32'd2, 32'd1});
    // extremes of the statistics, load and classify items, ignored columns
    add_row(nlc_pkg::OP_STATS, 2'd3, 5'd19, 32'h80000000, 1'b0, none);
    add_row(nlc_pkg::OP_STATS, 2'd0, 5'd19, 32'h7FFFFFFF, 1'b0, none);
    add_row(nlc_pkg::OP_STATS, 2'd0, 5'd31, 32'h12345678, 1'b0, none);
    add_row(nlc_pkg::OP_STATS, 2'd0, 5'd1, 32'h00010000, 1'b0, none);
    add_row(nlc_pkg::OP_LOAD, 2'd2, 5'd19, 32'h7FFFFFFF, 1'b0, none);
    add_row(nlc_pkg::OP_LOAD, 2'd1, 5'd20, 32'h80000000, 1'b0, none);
    add_row(nlc_pkg::OP_LOAD, 2'd3, 5'd21, 32'h55555555, 1'b0, none);
    add_row(nlc_pkg::OP_CLASS, 2'd0, 5'd19, 32'h7FFFFFFF, 1'b0, none);
    add_row(nlc_pkg::OP_CLASS, 2'd0, 5'd19, 32'h80000000, 1'b0, none);
    add_row(nlc_pkg::OP_CLASS, 2'd0, 5'd1, 32'h00010000, 1'b0, none);
    add_row(nlc_pkg::OP_CLASS, 2'd0, 5'd20, 32'hFFFFFFFF, 1'b0, none);
    add_row(nlc_pkg::OP_LABEL, 2'd2, 5'd0, 32'h0, 1'b0, none);
    add_row(nlc_pkg::OP_LABEL, 2'd1, 5'd0, 32'hFFFFFFFF, 1'b0, none);
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].beat);
      if (dir_rows[i].has_exp && label_queue.size() != 0 &&
          label_queue[$] !== dir_rows[i].exp_res) begin
        mismatches++;
        $display("directed row %0d: table %p predictor %p", i,
                 dir_rows[i].exp_res, label_queue[$]);
      end
    end
    drain();

    // random rows: mostly well-formed rows, some noise
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 84 : 0;
      while (items_sent < 150 + (phase + 1) * 520) begin
        case ($urandom_range(9))
          0: send_beat(make_beat(2'($urandom), 2'($urandom), 5'($urandom), rand_value()));
          1, 2: for (i = 0; i < 4; i++)
            send_beat(make_beat(nlc_pkg::OP_LOAD, 2'($urandom), 5'($urandom_range(20)),
                                rand_value()));
          3, 4: for (i = 0; i < 4; i++)
            send_beat(make_beat(nlc_pkg::OP_STATS, 2'($urandom), 5'($urandom_range(21)),
                                rand_value()));
          default: begin
            k = $urandom_range(6);
            for (i = 0; i < k; i++) begin
              col = $urandom_range(20);
              send_beat(make_beat(nlc_pkg::OP_CLASS, 2'($urandom), 5'(col),
                        ($urandom_range(3) == 0) ? rand_value()
                          : 32'(col_min[col < NF ? col : 0] + $urandom_range(65536))));
            end
            send_beat(make_beat(nlc_pkg::OP_LABEL, 2'($urandom), 5'($urandom), $urandom));
          end
        endcase
      end
      // hold off until every label result is back
      drain();
    end

    $display("covered %0d input beats and %0d label results across three idling mixes",
             items_sent, labels_seen);
    if (mismatches == 0) begin
      $display("normalized_linear_classifier_top regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("normalized_linear_classifier_top regression: fail");
    end
    $finish;
  end

endmodule
